/* hw/rtl/utf8d_pkg.sv */
// ============================================================================
// utf8d_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ============================================================================
package utf8d_pkg;

  localparam int COUNT_BITS = 16;
  localparam int BYTE_W     = 8;
  localparam int CP_W       = 21;
  localparam int WIDTH_W    = 3;
  localparam int STATUS_W   = 2;
  localparam int CHAR_CNT_W = 16;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  localparam logic [BYTE_W-1:0] MASK_1 = 8'h80;
  localparam logic [BYTE_W-1:0] MASK_2 = 8'hE0;
  localparam logic [BYTE_W-1:0] PFX_2  = 8'hC0;
  localparam logic [BYTE_W-1:0] MASK_3 = 8'hF0;
  localparam logic [BYTE_W-1:0] PFX_3  = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_4 = 8'hF8;
  localparam logic [BYTE_W-1:0] PFX_4  = 8'hF0;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_TRUNC    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CL_ASCII,
    CL_LEAD2,
    CL_LEAD3,
    CL_LEAD4,
    CL_OTHER
  } lead_class_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              span_end;
    lead_class_t       cls;
  } front_item_t;

endpackage

/* hw/rtl/utf8d_byte_if.sv */
// ============================================================================
// utf8d_byte_if
// Byte channel: one raw byte of a span per item, with an end-of-span flag.
// ============================================================================
interface utf8d_byte_if;
  logic                        valid;
  logic                        ready;
  logic [utf8d_pkg::BYTE_W-1:0] in_byte;
  logic                        span_end;

  modport source (output valid, in_byte, span_end, input ready);
  modport sink   (input valid, in_byte, span_end, output ready);
endinterface

/* hw/rtl/utf8d_cp_if.sv */
// ============================================================================
// utf8d_cp_if
// Result channel: one decoded codepoint or error status per item.
// ============================================================================
interface utf8d_cp_if;
  logic                            valid;
  logic                            ready;
  logic [utf8d_pkg::CP_W-1:0]       codepoint;
  logic [utf8d_pkg::WIDTH_W-1:0]    width;
  logic [utf8d_pkg::STATUS_W-1:0]   status;
  logic                            is_last;
  logic [utf8d_pkg::CHAR_CNT_W-1:0] char_count;

  modport source (output valid, codepoint, width, status, is_last, char_count,
                  input ready);
  modport sink   (input valid, codepoint, width, status, is_last, char_count,
                  output ready);
endinterface

/* hw/rtl/utf8d_front.sv */
// ============================================================================
// utf8d_front
// Accepts bytes, classifies the prefix and registers the classified item.
// ============================================================================
module utf8d_front (
  input  logic                   clk,
  input  logic                   rst,
  utf8d_byte_if.sink             data,
  output logic                   push_valid,
  input  logic                   push_ready,
  output utf8d_pkg::front_item_t push_item
);
  import utf8d_pkg::*;

  logic        stage_valid;
  front_item_t stage_item;
  lead_class_t cls_next;

  assign data.ready = !stage_valid || push_ready;
  assign push_valid = stage_valid;
  assign push_item  = stage_item;

  always_comb begin
    priority if ((data.in_byte & MASK_1) == 8'h00) begin
      cls_next = CL_ASCII;
    end else if ((data.in_byte & MASK_2) == PFX_2) begin
      cls_next = CL_LEAD2;
    end else if ((data.in_byte & MASK_3) == PFX_3) begin
      cls_next = CL_LEAD3;
    end else if ((data.in_byte & MASK_4) == PFX_4) begin
      cls_next = CL_LEAD4;
    end else begin
      cls_next = CL_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (data.ready) begin
      stage_valid <= data.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data.valid && data.ready) begin
      stage_item.data     <= data.in_byte;
      stage_item.span_end <= data.span_end;
      stage_item.cls      <= cls_next;
    end
  end

endmodule

/* hw/rtl/utf8d_queue.sv */
// ============================================================================
// utf8d_queue
// Two-entry queue between the classifier and the decode engine.
// ============================================================================
module utf8d_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  utf8d_pkg::front_item_t push_item,
  output logic                   pop_valid,
  input  logic                   pop_ready,
  output utf8d_pkg::front_item_t pop_item
);
  import utf8d_pkg::*;

  front_item_t entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push_fire;
  logic        pop_fire;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entries[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_fire) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop_fire) begin
        rd_ptr <= !rd_ptr;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 2'd1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

/* hw/rtl/utf8d_back.sv */
// ============================================================================
// utf8d_back
// Decode engine: sequence state, error tracking, char count, result register.
// ============================================================================
module utf8d_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  utf8d_pkg::front_item_t pop_item,
  utf8d_cp_if.source             result
);
  import utf8d_pkg::*;

  logic [1:0]            bytes_left,    bytes_left_next;
  logic [CP_W-1:0]       partial_value, partial_value_next;
  logic [WIDTH_W-1:0]    seq_width,     seq_width_next;
  status_t               sticky_error,  sticky_error_next;
  logic [COUNT_BITS-1:0] chars_seen,    chars_seen_next;

  logic [COUNT_BITS-1:0] count_inc;
  logic [CP_W-1:0]       shifted;
  logic                  has_res;
  logic                  clear_all;
  logic [CP_W-1:0]       res_cp;
  logic [WIDTH_W-1:0]    res_width;
  status_t               res_status;
  logic                  res_last;
  logic                  advance;
  logic                  pop_fire;

  logic                  out_valid;
  logic [CP_W-1:0]       out_cp;
  logic [WIDTH_W-1:0]    out_width;
  status_t               out_status;
  logic                  out_last;
  logic [COUNT_BITS-1:0] out_count;

  assign advance   = !out_valid || result.ready;
  assign pop_ready = advance;
  assign pop_fire  = pop_valid && advance;

  assign count_inc = (chars_seen == CNT_MAX) ? chars_seen
                                             : chars_seen + COUNT_BITS'(1);
  assign shifted   = {partial_value[CP_W-7:0], pop_item.data[5:0]};

  always_comb begin
    bytes_left_next    = bytes_left;
    partial_value_next = partial_value;
    seq_width_next     = seq_width;
    sticky_error_next  = sticky_error;
    chars_seen_next    = chars_seen;
    has_res            = 1'b0;
    res_cp             = '0;
    res_width          = '0;
    res_status         = ST_OK;
    res_last           = pop_item.span_end;
    if (sticky_error != ST_OK) begin
      has_res    = pop_item.span_end;
      res_status = sticky_error;
    end else if (bytes_left == 2'd0) begin
      unique case (pop_item.cls)
        CL_ASCII: begin
          chars_seen_next = count_inc;
          has_res         = 1'b1;
          res_cp          = CP_W'(pop_item.data[6:0]);
          res_width       = WIDTH_W'(1);
        end
        CL_LEAD2: begin
          partial_value_next = CP_W'(pop_item.data[4:0]);
          bytes_left_next    = 2'd1;
          seq_width_next     = WIDTH_W'(2);
          has_res            = pop_item.span_end;
          res_status         = ST_TRUNC;
        end
        CL_LEAD3: begin
          partial_value_next = CP_W'(pop_item.data[3:0]);
          bytes_left_next    = 2'd2;
          seq_width_next     = WIDTH_W'(3);
          has_res            = pop_item.span_end;
          res_status         = ST_TRUNC;
        end
        CL_LEAD4: begin
          partial_value_next = CP_W'(pop_item.data[2:0]);
          bytes_left_next    = 2'd3;
          seq_width_next     = WIDTH_W'(4);
          has_res            = pop_item.span_end;
          res_status         = ST_TRUNC;
        end
        default: begin
          sticky_error_next = ST_BAD_LEAD;
          has_res           = pop_item.span_end;
          res_status        = ST_BAD_LEAD;
        end
      endcase
    end else if (bytes_left == 2'd1) begin
      chars_seen_next    = count_inc;
      bytes_left_next    = 2'd0;
      partial_value_next = '0;
      seq_width_next     = '0;
      has_res            = 1'b1;
      res_cp             = shifted;
      res_width          = seq_width;
    end else begin
      partial_value_next = shifted;
      bytes_left_next    = bytes_left - 2'd1;
      has_res            = pop_item.span_end;
      res_status         = ST_TRUNC;
    end
  end

  assign clear_all = has_res && res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= 2'd0;
      partial_value <= '0;
      seq_width     <= '0;
      sticky_error  <= ST_OK;
      chars_seen    <= '0;
    end else if (pop_fire) begin
      if (clear_all) begin
        bytes_left    <= 2'd0;
        partial_value <= '0;
        seq_width     <= '0;
        sticky_error  <= ST_OK;
        chars_seen    <= '0;
      end else begin
        bytes_left    <= bytes_left_next;
        partial_value <= partial_value_next;
        seq_width     <= seq_width_next;
        sticky_error  <= sticky_error_next;
        chars_seen    <= chars_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= pop_fire && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire && has_res) begin
      out_cp     <= res_cp;
      out_width  <= res_width;
      out_status <= res_status;
      out_last   <= res_last;
      out_count  <= chars_seen_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.codepoint  = out_cp;
  assign result.width      = out_width;
  assign result.status     = out_status;
  assign result.is_last    = out_last;
  assign result.char_count = CHAR_CNT_W'(out_count);

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_OK) |->
      (out_cp == '0 && out_width == '0 && out_last))
    else $error("error result carries data");

  a_ok_width: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ST_OK) |-> (out_width != '0))
    else $error("ok result with zero width");

  a_no_open_seq_on_error: assert property (@(posedge clk) disable iff (rst)
    (sticky_error != ST_OK) |-> (bytes_left == 2'd0))
    else $error("sequence open while error is sticky");

  a_span_clear: assert property (@(posedge clk) disable iff (rst)
    (pop_fire && clear_all) |=>
      (bytes_left == 2'd0 && chars_seen == '0 && sticky_error == ST_OK))
    else $error("state not cleared at span end");

endmodule

/* hw/rtl/utf8_stream_decoder_unit.sv */
// ============================================================================
// utf8_stream_decoder_unit
// Streaming UTF-8 decoder: one codepoint per complete sequence, one error status per failed span.
// Path: a byte is registered in the front stage, queued, and its result registered.
// Throughput: one byte per cycle unless the result receiver holds off ready.
// Reset: synchronous rst empties the stage and queue and clears all span state.
// ============================================================================
module utf8_stream_decoder_unit (
  input logic        clk,
  input logic        rst,
  utf8d_byte_if.sink data,
  utf8d_cp_if.source result
);
  import utf8d_pkg::*;

  logic        push_valid;
  logic        push_ready;
  front_item_t push_item;
  logic        pop_valid;
  logic        pop_ready;
  front_item_t pop_item;

  utf8d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .data       (data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  utf8d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  utf8d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .result    (result)
  );

endmodule

/* sim/utf8_stream_decoder_unit_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// utf8_stream_decoder_unit_tb
// Self-checking bench for the UTF-8 stream decoder. A driver feeds bytes from
// a queue, a bit-accurate decoder model predicts each codepoint or error item,
// and a monitor compares every result item field by field. Runs a directed
// set, random spans under several idle/stall mixes and a long receiver
// hold-off.
// ============================================================================
module utf8_stream_decoder_unit_tb;
  import utf8d_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [BYTE_W-1:0] b;
    logic              last;
  } span_byte_t;

  typedef struct {
    logic [CP_W-1:0]       cp;
    logic [WIDTH_W-1:0]    w;
    status_t               st;
    logic                  last;
    logic [CHAR_CNT_W-1:0] cnt;
  } cp_result_t;

  logic clk;
  logic rst;

  utf8d_byte_if byte_ch ();
  utf8d_cp_if   cp_ch ();

  utf8_stream_decoder_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .data   (byte_ch),
    .result (cp_ch)
  );

  span_byte_t byte_queue[$];
  cp_result_t expected_codepoints[$];
  span_byte_t next_byte;
  int         mismatch_count = 0;
  int         queued_bytes = 0;
  int         cycle_count = 0;
  int         tx_idle_pct = 0;
  int         rx_stall_pct = 0;
  logic       rx_hold = 1'b0;
  logic       hold_go = 1'b0;
  logic       hold_done = 1'b0;

  // decoder model state
  logic [1:0]            dec_left;
  logic [CP_W-1:0]       dec_partial;
  logic [WIDTH_W-1:0]    dec_seq_w;
  status_t               dec_sticky;
  logic [COUNT_BITS-1:0] dec_chars;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    byte_ch.valid    = 1'b0;
    byte_ch.in_byte  = '0;
    byte_ch.span_end = 1'b0;
    cp_ch.ready      = 1'b0;
  end

  function automatic void clear_span_state();
    dec_left    = '0;
    dec_partial = '0;
    dec_seq_w   = '0;
    dec_sticky  = ST_OK;
    dec_chars   = '0;
  endfunction

  function automatic void bump_chars();
    if (dec_chars != CNT_MAX)
      dec_chars = dec_chars + 1'b1;
  endfunction

  function automatic void push_expected(logic [CP_W-1:0] cp, logic [WIDTH_W-1:0] w,
                                        status_t st, logic last);
    cp_result_t r;
    r.cp   = cp;
    r.w    = w;
    r.st   = st;
    r.last = last;
    r.cnt  = CHAR_CNT_W'(dec_chars);
    expected_codepoints.push_back(r);
  endfunction

  function automatic void decode_step(logic [BYTE_W-1:0] b, logic last);
    logic opened;
    opened = 1'b0;
    if (dec_sticky != ST_OK) begin
      if (last) begin
        push_expected('0, '0, dec_sticky, 1'b1);
        clear_span_state();
      end
    end else if (dec_left == 2'd0) begin
      if ((b & MASK_1) == 8'h00) begin
        bump_chars();
        push_expected(CP_W'(b), 3'd1, ST_OK, last);
        if (last)
          clear_span_state();
      end else if ((b & MASK_2) == PFX_2) begin
        dec_partial = CP_W'(b[4:0]);
        dec_left    = 2'd1;
        dec_seq_w   = 3'd2;
        opened      = 1'b1;
      end else if ((b & MASK_3) == PFX_3) begin
        dec_partial = CP_W'(b[3:0]);
        dec_left    = 2'd2;
        dec_seq_w   = 3'd3;
        opened      = 1'b1;
      end else if ((b & MASK_4) == PFX_4) begin
        dec_partial = CP_W'(b[2:0]);
        dec_left    = 2'd3;
        dec_seq_w   = 3'd4;
        opened      = 1'b1;
      end else begin
        dec_sticky = ST_BAD_LEAD;
        if (last) begin
          push_expected('0, '0, ST_BAD_LEAD, 1'b1);
          clear_span_state();
        end
      end
      if (opened && last) begin
        push_expected('0, '0, ST_TRUNC, 1'b1);
        clear_span_state();
      end
    end else begin
      dec_partial = {dec_partial[CP_W-7:0], b[5:0]};
      dec_left    = dec_left - 2'd1;
      if (dec_left == 2'd0) begin
        bump_chars();
        push_expected(dec_partial, dec_seq_w, ST_OK, last);
        dec_partial = '0;
        dec_seq_w   = '0;
        if (last)
          clear_span_state();
      end else if (last) begin
        push_expected('0, '0, ST_TRUNC, 1'b1);
        clear_span_state();
      end
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
      clear_span_state();
    end else begin
      if (byte_ch.valid && byte_ch.ready)
        decode_step(byte_ch.in_byte, byte_ch.span_end);
      if (!byte_ch.valid || byte_ch.ready) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_byte = byte_queue.pop_front();
          byte_ch.valid    <= 1'b1;
          byte_ch.in_byte  <= next_byte.b;
          byte_ch.span_end <= next_byte.last;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    cp_result_t want;
    if (rst) begin
      cp_ch.ready <= 1'b0;
    end else begin
      if (cp_ch.valid && cp_ch.ready) begin
        if (expected_codepoints.size() == 0) begin
          flag_mismatch("unexpected item, codepoint", 32'(cp_ch.codepoint), 32'd0);
        end else begin
          want = expected_codepoints.pop_front();
          if (cp_ch.codepoint !== want.cp)
            flag_mismatch("codepoint", 32'(cp_ch.codepoint), 32'(want.cp));
          if (cp_ch.width !== want.w)
            flag_mismatch("width", 32'(cp_ch.width), 32'(want.w));
          if (cp_ch.status !== want.st)
            flag_mismatch("status", 32'(cp_ch.status), 32'(want.st));
          if (cp_ch.is_last !== want.last)
            flag_mismatch("is_last", 32'(cp_ch.is_last), 32'(want.last));
          if (cp_ch.char_count !== want.cnt)
            flag_mismatch("char_count", 32'(cp_ch.char_count), 32'(want.cnt));
        end
      end
      cp_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // long receiver hold-off
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold   <= 1'b0;
    hold_done <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
    span_byte_t it;
    it.b    = b;
    it.last = last;
    byte_queue.push_back(it);
    queued_bytes++;
  endtask

  function automatic logic [BYTE_W-1:0] lead_byte(int w);
    logic [BYTE_W-1:0] b;
    b = 8'($urandom);
    case (w)
      1:       b[7]   = 1'b0;
      2:       b[7:5] = 3'b110;
      3:       b[7:4] = 4'b1110;
      default: b[7:3] = 5'b11110;
    endcase
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] cont_byte();
    if ($urandom_range(99) < 6)
      return 8'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  // one span of nchars characters, mostly well formed
  task automatic push_span(input int nchars);
    logic [BYTE_W-1:0] sb[$];
    int kind;
    int w;
    int ncont;
    for (int i = 0; i < nchars; i++) begin
      kind = $urandom_range(99);
      if (kind < 82) begin
        w = $urandom_range(1, 4);
        sb.push_back(lead_byte(w));
        for (int k = 1; k < w; k++)
          sb.push_back(cont_byte());
      end else if (kind < 90) begin
        sb.push_back($urandom_range(1) ? {2'b10, 6'($urandom)} : {5'b11111, 3'($urandom)});
      end else begin
        w = $urandom_range(2, 4);
        ncont = $urandom_range(0, w - 2);
        sb.push_back(lead_byte(w));
        for (int k = 0; k < ncont; k++)
          sb.push_back(cont_byte());
      end
    end
    foreach (sb[i])
      push_byte(sb[i], i == sb.size() - 1);
  endtask

  task automatic push_random_items(input int n);
    int stop_at;
    int len;
    stop_at = queued_bytes + n;
    while (queued_bytes < stop_at) begin
      if ($urandom_range(99) < 8) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          push_byte(8'($urandom), i == len - 1);
      end else begin
        push_span($urandom_range(1, 6));
      end
    end
  endtask

  task automatic drain();
    do
      @(negedge clk);
    while (byte_queue.size() != 0 || byte_ch.valid || expected_codepoints.size() != 0);
  endtask

  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes of each width, bad leads, truncation, unchecked continuation
    push_byte(8'h00, 1'b1);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hDF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hF7, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b1);
    push_byte(8'h80, 1'b1);
    push_byte(8'hF8, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'hC2, 1'b1);
    push_byte(8'hE2, 1'b0);
    push_byte(8'h82, 1'b1);
    push_byte(8'hF0, 1'b1);
    push_byte(8'hC3, 1'b0);
    push_byte(8'h00, 1'b1);
    drain();

    push_random_items(130);
    drain();

    tx_idle_pct = 58;
    push_random_items(130);
    drain();

    tx_idle_pct  = 0;
    rx_stall_pct = 58;
    push_random_items(130);
    drain();

    tx_idle_pct  = 16;
    rx_stall_pct = 16;
    push_random_items(130);
    drain();

    // receiver holds off while the sender keeps offering
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_go = 1'b1;
    push_random_items(80);
    while (!hold_done)
      @(negedge clk);
    drain();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
